[hdl/sliding_window_median_filter_unit_macros.svh]
// assertion macros for the sliding window median filter
// used by the rtl files that check their own control; needs a clk and rst in scope
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SWMF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swmf check failed");

// antecedent implies consequent in the next cycle
`define SWMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swmf check failed");

`endif

[hdl/swmf_pkg.sv]
// shared constants and types for the sliding window median filter
// no dependencies
`default_nettype none

package swmf_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int SAMPLE_W     = 8;
  localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int BIT_W        = (SAMPLE_W > 1) ? $clog2(SAMPLE_W) : 1;
  localparam int MEDIAN_RANK  = WINDOW_DEPTH / 2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // control from the sequencer to the window and selector
  typedef struct packed {
    logic load;   // new sample transfer: write window, restart selection
    logic step;   // one bit step of the selection
  } ctl_t;

endpackage

`default_nettype wire

[hdl/swmf_window.sv]
// sample window: circular store of bit-rotating shift registers
// depends on swmf_pkg
`default_nettype none

module swmf_window (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire swmf_pkg::ctl_t                 ctl,
  input  wire swmf_pkg::sample_t              sample,
  output logic [swmf_pkg::WINDOW_DEPTH-1:0]   msb_bits
);
  import swmf_pkg::*;

  sample_t          entries [WINDOW_DEPTH];
  logic [PTR_W-1:0] wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        entries[i] <= '0;
      end
    end else if (ctl.load) begin
      entries[wr_ptr] <= sample;
      if (wr_ptr == PTR_W'(WINDOW_DEPTH - 1)) begin
        wr_ptr <= '0;
      end else begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
    end else if (ctl.step) begin
      // rotate left; after SAMPLE_W steps every entry is back in place
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        entries[i] <= {entries[i][SAMPLE_W-2:0], entries[i][SAMPLE_W-1]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      msb_bits[i] = entries[i][SAMPLE_W-1];
    end
  end

endmodule

`default_nettype wire

[hdl/swmf_select.sv]
// bit-serial rank selector: finds the median one result bit per step, msb first
// depends on swmf_pkg
`default_nettype none

module swmf_select (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire swmf_pkg::ctl_t                 ctl,
  input  wire logic [swmf_pkg::WINDOW_DEPTH-1:0] msb_bits,
  output swmf_pkg::sample_t                   result
);
  import swmf_pkg::*;

  logic [WINDOW_DEPTH-1:0] cand, cand_next;
  logic [CNT_W-1:0]        rank, rank_next;
  logic [CNT_W-1:0]        zero_cnt;
  logic                    res_bit;

  // candidates whose current bit is zero
  always_comb begin
    zero_cnt = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      zero_cnt = zero_cnt + CNT_W'(cand[i] & ~msb_bits[i]);
    end
    res_bit = (rank >= zero_cnt);
    if (res_bit) begin
      cand_next = cand & msb_bits;
      rank_next = rank - zero_cnt;
    end else begin
      cand_next = cand & ~msb_bits;
      rank_next = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '1;
      rank <= CNT_W'(MEDIAN_RANK);
    end else if (ctl.load) begin
      cand <= '1;
      rank <= CNT_W'(MEDIAN_RANK);
    end else if (ctl.step) begin
      cand <= cand_next;
      rank <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      result <= {result[SAMPLE_W-2:0], res_bit};
    end
  end

endmodule

`default_nettype wire

[hdl/sliding_window_median_filter_unit.sv]
// sliding window median filter: each rssi sample enters an 8-entry circular
// window and the median of the window is returned, upper median for even depth.
// The input channel (in_valid, in_stall, rssi_sample) takes one sample per
// transfer; the output channel (out_valid, out_stall, median_value) gives
// exactly one median per sample, in order.
// On an input transfer the window is written at the transfer edge, then a
// bit-serial rank selection runs, one result bit per cycle, msb first, one
// step per sample bit; then the output register is loaded and out_valid rises.
// Each sample is finished before the next one is accepted.
// A new sample is taken as soon as the previous median sits in the output
// register, so a waiting result does not block the input.
// If the receiver stalls with a result still held, the finished median waits
// in the selector and in_stall stays high until the output register frees.
// Reset (rst, synchronous) clears the window to zeros, the write pointer and
// out_valid; unwritten entries take part in the median as zeros.
// depends on swmf_pkg, swmf_window, swmf_select and the macros header
`default_nettype none
`include "sliding_window_median_filter_unit_macros.svh"

module sliding_window_median_filter_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire swmf_pkg::sample_t    rssi_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output swmf_pkg::sample_t         median_value
);
  import swmf_pkg::*;

  state_t                  state, state_next;
  ctl_t                    ctl;
  logic [BIT_W-1:0]        bit_idx;
  logic [WINDOW_DEPTH-1:0] msb_bits;
  sample_t                 result;
  logic                    out_load;
  logic                    in_xfer;

  assign in_xfer = in_valid & ~in_stall;

  swmf_window u_window (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sample   (rssi_sample),
    .msb_bits (msb_bits)
  );

  swmf_select u_select (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .msb_bits (msb_bits),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.step = 1'b1;
        if (bit_idx == BIT_W'(SAMPLE_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_load = ~out_valid | ~out_stall;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_idx <= '0;
    end else if (ctl.load) begin
      bit_idx <= '0;
    end else if (ctl.step) begin
      bit_idx <= bit_idx + BIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_value <= result;
    end
  end

  `SWMF_ASSERT_NEXT(a_xfer_starts_scan, in_xfer, state == ST_SCAN && bit_idx == '0)
  `SWMF_ASSERT_NEXT(a_scan_ends_done, state == ST_SCAN && bit_idx == BIT_W'(SAMPLE_W - 1),
                    state == ST_DONE)
  `SWMF_ASSERT_SAME(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE)
  `SWMF_ASSERT_SAME(a_stall_while_busy, state != ST_IDLE, in_stall)

endmodule

`default_nettype wire
